[hdl/ats_pkg.sv]
package ats_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_ADD = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FIRED = 3'd3;
    localparam logic [2:0] ST_IDLE = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [39:0] now;
        logic [31:0] job_id;
        logic        kind;
        logic [31:0] period;
        logic [39:0] at_time;
        logic        delete_once;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] fired_id;
        logic        last;
        logic [4:0]  entries;
    } t_out;

    typedef struct packed {
        logic [31:0] id;
        logic        kind;
        logic [31:0] interval;
        logic [39:0] at_time;
        logic        enabled;
        logic        delete_once;
        logic [39:0] next_due;
    } t_entry;

    // per-cycle command to every cell
    typedef struct packed {
        logic       rotate;
        logic       load;
    } t_cell_ctl;

    function automatic logic [39:0] sat_add(input logic [39:0] t, input logic [31:0] d);
        logic [40:0] s;
        s = {1'b0, t} + {9'd0, d};
        return s[40] ? TIME_MAX : s[39:0];
    endfunction

endpackage

[hdl/alarm_table_scheduler.sv]
// alarm_table_scheduler: table of up to MAX_JOBS timer jobs.
// Input: drive the transaction fields on i_in and raise start; the transaction
// is taken at the rising edge where start is high and busy is low.
// Output: each result is shown on o_out for one cycle with o_valid high; the
// receiver must take it then, it cannot stall the block.
// Add and the unused func code: busy through a single done state; the single
// result is shown as it returns to idle, when it can take the next one.
// Remove and tick: the table is a chain of MAX_JOBS cells that rotates one slot
// per cycle over the N jobs held, so the head cell inspects every job in turn.
// A removed job or a fired delete-once job is not passed back into the chain,
// which closes the gap. Busy through the walk, a closing walk step and the done
// state; the final result is shown as it returns to idle. A fired job gives one
// result, sent when the next firing is found or as the final result; the final
// result of a transaction carries last=1. No transaction is taken while busy.
// Reset (synchronous, i_rst_n low) empties the table; entry contents stay
// undefined until written.
module alarm_table_scheduler
    import ats_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_valid,
    output t_out o_out
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] r_left;
    t_in              r_cmd;
    logic             r_found;
    logic             r_hold_v;
    logic [31:0]      r_hold_id;
    logic             r_valid;
    t_out             r_out;

    t_entry    ent [MAX_JOBS];
    t_entry    head;
    t_entry    upd;
    t_entry    newe;
    t_cell_ctl ctl;
    logic      active;
    logic      due;
    logic      drop_h;
    logic      fire;

    assign head = ent[0];
    assign active = (r_step < r_count);
    assign due = active && head.enabled && head.next_due != 40'd0 &&
                 head.next_due <= r_cmd.now;
    assign fire = due && r_cmd.func == FN_TICK;

    always_comb begin
        upd = head;
        drop_h = 1'b0;
        if (r_cmd.func == FN_REMOVE) begin
            drop_h = active && !r_found && head.id == r_cmd.job_id;
        end else if (due) begin
            if (head.kind) begin
                drop_h = head.delete_once;
                upd.enabled = 1'b0;
                upd.next_due = 40'd0;
            end else begin
                upd.next_due = sat_add(r_cmd.now, head.interval);
            end
        end
    end

    always_comb begin
        newe.id = i_in.job_id;
        newe.kind = i_in.kind;
        newe.interval = i_in.period;
        newe.at_time = i_in.at_time;
        newe.delete_once = i_in.delete_once;
        newe.enabled = 1'b1;
        newe.next_due = sat_add(i_in.now, i_in.period);
        if (i_in.kind) begin
            newe.enabled = i_in.at_time > i_in.now;
            newe.next_due = (i_in.at_time > i_in.now) ? i_in.at_time : 40'd0;
        end
    end

    assign ctl.rotate = (r_state == S_WALK) && active;
    assign ctl.load = (r_state == S_IDLE) && start && i_in.func == FN_ADD &&
                      r_count < CNT_W'(MAX_JOBS);

    // cell k takes from k+1; the last held job takes the head's updated value
    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
        logic   tail;
        t_entry nxt;
        always_comb begin
            nxt = (k == MAX_JOBS - 1) ? upd : ent[(k + 1) % MAX_JOBS];
            if (CNT_W'(k) == r_left - 1'b1) begin
                nxt = upd;
            end
            tail = (r_count == CNT_W'(k));
        end
        ats_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_is_tail  (tail),
            .i_load_val (newe),
            .i_next     (nxt),
            .o_entry    (ent[k])
        );
    end

    // Walk: each step the head leaves, the rest shift down, and the head's
    // updated value goes to slot r_left-1, past the held jobs if dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_step <= '0;
            r_left <= '0;
            r_found <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (start) begin
                        r_cmd <= i_in;
                        r_step <= '0;
                        r_left <= r_count;
                        r_found <= 1'b0;
                        r_hold_v <= 1'b0;
                        if (i_in.func == FN_TICK || i_in.func == FN_REMOVE) begin
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_DONE;
                            r_out.fired_id <= '0;
                            r_out.last <= 1'b1;
                            if (i_in.func == FN_ADD) begin
                                if (r_count < CNT_W'(MAX_JOBS)) begin
                                    r_count <= r_count + 1'b1;
                                    r_out.status <= ST_OK;
                                    r_out.entries <= 5'(r_count + 1'b1);
                                end else begin
                                    r_out.status <= ST_FULL;
                                    r_out.entries <= 5'(r_count);
                                end
                            end else begin
                                r_out.status <= ST_OK;
                                r_out.entries <= 5'(r_count);
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (active) begin
                        r_valid <= fire && r_hold_v;
                        if (drop_h) begin
                            r_left <= r_left - 1'b1;
                            r_count <= r_count - 1'b1;
                            if (r_cmd.func == FN_REMOVE) begin
                                r_found <= 1'b1;
                            end
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                        if (fire) begin
                            if (r_hold_v) begin
                                r_out <= '{ST_FIRED, r_hold_id, 1'b0,
                                          5'(r_count)};
                            end
                            r_hold_v <= 1'b1;
                            r_hold_id <= head.id;
                        end
                    end else begin
                        r_valid <= 1'b0;
                        r_state <= S_DONE;
                        r_out.last <= 1'b1;
                        r_out.entries <= 5'(r_count);
                        if (r_cmd.func == FN_REMOVE) begin
                            r_out.status <= r_found ? ST_OK : ST_NOTFOUND;
                            r_out.fired_id <= '0;
                        end else if (r_hold_v) begin
                            r_out.status <= ST_FIRED;
                            r_out.fired_id <= r_hold_id;
                        end else begin
                            r_out.status <= ST_IDLE;
                            r_out.fired_id <= '0;
                        end
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid && (r_state == S_IDLE || r_state == S_WALK);
    assign o_out = r_out;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_JOBS)) else $error("count overflow");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |-> r_state == S_IDLE) else $error("last early");
endmodule

[hdl/ats_cell.sv]
// Table slot: tail loads a job; on rotate takes i_next. Cell 0 is the head.
module ats_cell
    import ats_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_is_tail,
    input  t_entry    i_load_val,
    input  t_entry    i_next,
    output t_entry    o_entry
);
    t_entry r_e;
    t_entry n_e;

    always_comb begin
        n_e = r_e;
        if (i_ctl.load && i_is_tail) begin
            n_e = i_load_val;
        end else if (i_ctl.rotate) begin
            n_e = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_entry = r_e;
endmodule
